// ===== hdl/crst_pkg.sv =====
// Shared types and constants for the call/return stack tracer.
package crst_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int SYM_ENTRIES = 256;

    localparam int SYM_AW  = (SYM_ENTRIES > 1) ? $clog2(SYM_ENTRIES) : 1;
    localparam int SYM_CW  = $clog2(SYM_ENTRIES + 1);
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

    localparam int ADDR_W  = 32;
    localparam int NAME_W  = 16;
    localparam int LREG_W  = 5;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 88;

    localparam logic [LREG_W-1:0] LREG_RETURN = LREG_W'(1);
    localparam logic [ADDR_W-1:0] RET_OFFSET  = ADDR_W'(4);

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_JUMP = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_CALL    = 2'd0,
        KIND_RET     = 2'd1,
        KIND_NOMATCH = 2'd2,
        KIND_FULL    = 2'd3
    } kind_t;

    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [ADDR_W-1:0] entry;
        logic [ADDR_W-1:0] ret;
    } frame_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stk_ctl_t;

endpackage

// ===== hdl/crst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module crst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/crst_cell.sv =====
// One frame slot of the shifting shadow stack.
module crst_cell (
    input  logic              aclk,
    input  crst_pkg::stk_ctl_t ctl,
    input  crst_pkg::frame_t  up_frame,
    input  crst_pkg::frame_t  down_frame,
    output crst_pkg::frame_t  frame
);
    import crst_pkg::*;

    frame_t frame_reg;
    frame_t frame_next;

    // push moves frames away from the top, pop moves them toward it
    always_comb begin
        frame_next = frame_reg;
        if (ctl.push) begin
            frame_next = up_frame;
        end else if (ctl.pop) begin
            frame_next = down_frame;
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
    end

    assign frame = frame_reg;

endmodule

// ===== hdl/call_return_stack_tracer.sv =====
// Top level of the call/return shadow stack tracer.
//
// Takes one item at a time. A symbol load completes in the cycle it is
// taken. A call walks the symbol RAM in load order, reading each entry
// and then comparing it. A return pops one frame per cycle from a row of
// shifting stack cells, one result per popped frame, as fast as the result
// side takes them. The output register lets a result wait while the
// search of the next step goes on.
module call_return_stack_tracer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // pc[31:0], target_addr[63:32], link_reg[68:64], sym_addr[100:69],
    // sym_name_id[116:101], zero fill
    input  logic [crst_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // event_pc[31:0], func_name_id[47:32], entry_addr[79:48],
    // nesting_depth[86:80], zero fill
    output logic [crst_pkg::M_TDATA_W-1:0] m_tdata,
    // event_kind
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast
);
    import crst_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SRD  = 4'b0010,
        ST_SCMP = 4'b0100,
        ST_RET  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [SYM_CW-1:0]  count_reg, count_next;
    logic [SYM_CW-1:0]  idx_reg, idx_next;
    logic [DEPTH_W-1:0] fill_reg, fill_next;
    logic [ADDR_W-1:0]  pc_reg, pc_next;
    logic [ADDR_W-1:0]  tgt_reg, tgt_next;

    logic               mvalid_reg, mvalid_next;
    logic [M_TDATA_W-1:0] mdata_reg, mdata_next;
    logic [1:0]         muser_reg, muser_next;
    logic               mlast_reg, mlast_next;

    logic [ADDR_W-1:0] in_pc, in_tgt, in_saddr;
    logic [LREG_W-1:0] in_lreg;
    logic [NAME_W-1:0] in_sname;
    logic              s_xfer, ofree, sym_we, hit;
    logic [ADDR_W+NAME_W-1:0] sym_rdata;
    logic [ADDR_W-1:0] sym_addr_rd;
    logic [NAME_W-1:0] sym_name_rd;

    stk_ctl_t ctl;
    frame_t   new_frame;
    frame_t   frames [STACK_DEPTH];
    frame_t   top;

    assign in_pc    = s_tdata[31:0];
    assign in_tgt   = s_tdata[63:32];
    assign in_lreg  = s_tdata[68:64];
    assign in_saddr = s_tdata[100:69];
    assign in_sname = s_tdata[116:101];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign ofree    = !mvalid_reg || m_tready;
    assign sym_we   = s_xfer && (s_tuser == CMD_LOAD) && (count_reg < SYM_CW'(SYM_ENTRIES));

    crst_ram #(
        .WIDTH(ADDR_W + NAME_W),
        .DEPTH(SYM_ENTRIES)
    ) u_sym_ram (
        .aclk  (aclk),
        .we    (sym_we),
        .waddr (count_reg[SYM_AW-1:0]),
        .wdata ({in_sname, in_saddr}),
        .raddr (idx_reg[SYM_AW-1:0]),
        .rdata (sym_rdata)
    );

    assign sym_addr_rd = sym_rdata[ADDR_W-1:0];
    assign sym_name_rd = sym_rdata[ADDR_W+NAME_W-1:ADDR_W];

    assign new_frame.name  = sym_name_rd;
    assign new_frame.entry = tgt_reg;
    assign new_frame.ret   = pc_reg + RET_OFFSET;

    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
            crst_cell u_cell (
                .aclk       (aclk),
                .ctl        (ctl),
                .up_frame   ((g == 0) ? new_frame : frames[(g == 0) ? 0 : g - 1]),
                .down_frame ((g == STACK_DEPTH - 1) ? frames[g]
                                                    : frames[(g == STACK_DEPTH - 1) ? g : g + 1]),
                .frame      (frames[g])
            );
        end
    endgenerate

    assign top = frames[0];
    assign hit = (top.ret == tgt_reg);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        fill_next   = fill_reg;
        pc_next     = pc_reg;
        tgt_next    = tgt_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;
        mlast_next  = mlast_reg;
        ctl         = '{push: 1'b0, pop: 1'b0};

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    pc_next  = in_pc;
                    tgt_next = in_tgt;
                    idx_next = '0;
                    if (s_tuser == CMD_LOAD) begin
                        if (sym_we) begin
                            count_next = count_reg + SYM_CW'(1);
                        end
                    end else if (in_lreg == LREG_RETURN) begin
                        state_next = ST_RET;
                    end else if (count_reg != '0) begin
                        state_next = ST_SRD;
                    end
                end
            end
            ST_SRD: begin
                state_next = ST_SCMP;
            end
            ST_SCMP: begin
                if (sym_addr_rd == tgt_reg) begin
                    if (ofree) begin
                        mvalid_next = 1'b1;
                        mlast_next  = 1'b1;
                        state_next  = ST_IDLE;
                        if (fill_reg == DEPTH_W'(STACK_DEPTH)) begin
                            muser_next = KIND_FULL;
                            mdata_next = M_TDATA_W'({DEPTH_W'(STACK_DEPTH), tgt_reg,
                                                     sym_name_rd, pc_reg});
                        end else begin
                            ctl.push   = 1'b1;
                            fill_next  = fill_reg + DEPTH_W'(1);
                            muser_next = KIND_CALL;
                            mdata_next = M_TDATA_W'({fill_next, tgt_reg,
                                                     sym_name_rd, pc_reg});
                        end
                    end
                end else begin
                    idx_next   = idx_reg + SYM_CW'(1);
                    state_next = (idx_next == count_reg) ? ST_IDLE : ST_SRD;
                end
            end
            ST_RET: begin
                if (ofree) begin
                    mvalid_next = 1'b1;
                    if (fill_reg == '0) begin
                        muser_next = KIND_NOMATCH;
                        mlast_next = 1'b1;
                        mdata_next = M_TDATA_W'(pc_reg);
                        state_next = ST_IDLE;
                    end else begin
                        ctl.pop    = 1'b1;
                        fill_next  = fill_reg - DEPTH_W'(1);
                        mlast_next = hit || (fill_next == '0);
                        muser_next = (!hit && fill_next == '0) ? KIND_NOMATCH : KIND_RET;
                        mdata_next = M_TDATA_W'({fill_next, top.entry, top.name, pc_reg});
                        if (mlast_next) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            fill_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            fill_reg   <= fill_next;
            mvalid_reg <= mvalid_next;
        end
        idx_reg   <= idx_next;
        pc_reg    <= pc_next;
        tgt_reg   <= tgt_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
        mlast_reg <= mlast_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;
    assign m_tlast  = mlast_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("stack fill above depth");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= SYM_CW'(SYM_ENTRIES))
        else $error("symbol count above table size");

    a_pop_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (mvalid_reg && !mlast_reg) |-> (state_reg == ST_RET))
        else $error("non-final result outside a pop run");

    a_empty_ret: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RET && fill_reg == '0 && ofree) |=> (state_reg == ST_IDLE))
        else $error("return on empty stack did not finish");
`endif

endmodule
